### rtl/hsd_pkg.sv
// Shared command, status and width constants for the Huffman stream decoder.
package hsd_pkg;

	localparam int BYTE_W = 8;
	localparam int WORD_W = 32;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_COUNT = 2'd1;
	localparam logic [1:0] CMD_BYTE  = 2'd2;
	localparam logic [1:0] CMD_END   = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_SYM   = 2'd1;
	localparam logic [1:0] ST_MISMATCH = 2'd2;
	localparam logic [1:0] ST_SHORT    = 2'd3;

endpackage

### rtl/hsd_tree_build.sv
// Count store, node weight and heap memories, and the sequencer that builds the code tree.
module hsd_tree_build
	import hsd_pkg::*;
#(
	parameter int SYMBOLS    = 256,
	parameter int NODE_SLOTS = 512
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cnt_clear,
	input  logic                            cnt_we,
	input  logic [$clog2(SYMBOLS)-1:0]      cnt_idx,
	input  logic [WORD_W-1:0]               cnt_data,
	input  logic                            build_start,
	output logic                            build_done,
	output logic [$clog2(NODE_SLOTS):0]     leaf_total,
	output logic [$clog2(NODE_SLOTS)-1:0]   tree_root,
	output logic                            node_we,
	output logic [$clog2(NODE_SLOTS)-1:0]   node_addr,
	output logic [$clog2(NODE_SLOTS)-1:0]   node_left,
	output logic [$clog2(NODE_SLOTS)-1:0]   node_right,
	output logic [BYTE_W-1:0]               node_sym
);

	localparam int SW       = $clog2(SYMBOLS);
	localparam int NW       = $clog2(NODE_SLOTS);
	localparam int LEAF_CAP = (NODE_SLOTS + 1) / 2;

	localparam logic [4:0] B_IDLE   = 5'd0;
	localparam logic [4:0] SC_RD    = 5'd1;
	localparam logic [4:0] SC_WR    = 5'd2;
	localparam logic [4:0] SC_END   = 5'd3;
	localparam logic [4:0] HP_NEXT  = 5'd4;
	localparam logic [4:0] SD_START = 5'd5;
	localparam logic [4:0] SD_LDN   = 5'd6;
	localparam logic [4:0] SD_LDW   = 5'd7;
	localparam logic [4:0] SD_L     = 5'd8;
	localparam logic [4:0] SD_LN    = 5'd9;
	localparam logic [4:0] SD_LW    = 5'd10;
	localparam logic [4:0] SD_RN    = 5'd11;
	localparam logic [4:0] SD_RW    = 5'd12;
	localparam logic [4:0] SD_CMP   = 5'd13;
	localparam logic [4:0] SD_END   = 5'd14;
	localparam logic [4:0] M_TOP    = 5'd15;
	localparam logic [4:0] P0       = 5'd16;
	localparam logic [4:0] P1       = 5'd17;
	localparam logic [4:0] M_JOIN   = 5'd18;
	localparam logic [4:0] PU_L     = 5'd19;
	localparam logic [4:0] PU_PN    = 5'd20;
	localparam logic [4:0] PU_PW    = 5'd21;
	localparam logic [4:0] PU_END   = 5'd22;
	localparam logic [4:0] B_DONE   = 5'd23;

	localparam logic [1:0] MD_HEAP = 2'd0;
	localparam logic [1:0] MD_POPA = 2'd1;
	localparam logic [1:0] MD_POPB = 2'd2;

	logic [WORD_W-1:0] cnt_mem  [SYMBOLS];
	logic [WORD_W-1:0] w_mem    [NODE_SLOTS];
	logic [NW-1:0]     heap_mem [NODE_SLOTS];

	logic [SYMBOLS-1:0] cnt_vld_q;
	logic [WORD_W-1:0]  cnt_rd_q, w_rd_q;
	logic [NW-1:0]      heap_rd_q;

	logic [4:0]    state_q;
	logic [1:0]    mode_q;
	logic [SW:0]   s_q;
	logic [NW:0]   u_q, fill_q, next_q;
	logic [NW-1:0] i_q, hi_q;
	logic [NW-1:0] n_q, ln_q, rn_q, pn_q, popped_q, a_q;
	logic [WORD_W-1:0] w_q, lw_q, rw_q, pw_q, wa_q;
	logic          rv_q;

	logic [NW-1:0]     ra_h, wa_h, wd_h;
	logic              we_h, we_w;
	logic [NW-1:0]     ra_w, wa_w;
	logic [WORD_W-1:0] wd_w;
	logic [NW+1:0]     l_pos, r_pos;
	logic [NW-1:0]     par_pos;
	logic [WORD_W-1:0] cnt_val, sum_w;
	logic              sel_l, sel_r;
	logic [WORD_W-1:0] best_w;

	assign l_pos   = {1'b0, i_q, 1'b1};
	assign r_pos   = {1'b0, i_q, 1'b0} + (NW+2)'(2);
	assign par_pos = NW'((i_q - NW'(1)) >> 1);
	assign cnt_val = cnt_vld_q[s_q[SW-1:0]] ? cnt_rd_q : '0;
	assign sum_w   = wa_q + pw_q;
	assign sel_l   = lw_q < w_q;
	assign best_w  = sel_l ? lw_q : w_q;
	assign sel_r   = rv_q && (rw_q < best_w);

	always_comb begin
		ra_h = i_q;
		ra_w = heap_rd_q;
		we_h = 1'b0;
		wa_h = i_q;
		wd_h = n_q;
		we_w = 1'b0;
		wa_w = u_q[NW-1:0];
		wd_w = cnt_val;
		node_we    = 1'b0;
		node_addr  = u_q[NW-1:0];
		node_left  = '0;
		node_right = '0;
		node_sym   = BYTE_W'(s_q);
		unique case (state_q)
			SC_WR: begin
				if (cnt_val != '0 && u_q < (NW+1)'(LEAF_CAP)) begin
					we_h = 1'b1;
					wa_h = u_q[NW-1:0];
					wd_h = u_q[NW-1:0];
					we_w = 1'b1;
					node_we = 1'b1;
				end
			end
			SD_L: ra_h = l_pos[NW-1:0];
			SD_LW: ra_h = r_pos[NW-1:0];
			SD_CMP: begin
				we_h = sel_l || sel_r;
				wd_h = sel_r ? rn_q : ln_q;
			end
			SD_END: we_h = 1'b1;
			P0: ra_h = '0;
			P1: ra_h = NW'(fill_q - (NW+1)'(1));
			M_JOIN: begin
				we_w = 1'b1;
				wa_w = next_q[NW-1:0];
				wd_w = sum_w;
				node_we    = 1'b1;
				node_addr  = next_q[NW-1:0];
				node_left  = a_q;
				node_right = popped_q;
				node_sym   = '0;
			end
			PU_L: ra_h = par_pos;
			PU_PW: begin
				we_h = w_q < w_rd_q;
				wd_h = pn_q;
			end
			PU_END: begin
				we_h = 1'b1;
				wd_h = next_q[NW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cnt_we)
			cnt_mem[cnt_idx] <= cnt_data;
		cnt_rd_q <= cnt_mem[s_q[SW-1:0]];
		if (we_w)
			w_mem[wa_w] <= wd_w;
		w_rd_q <= w_mem[ra_w];
		if (we_h)
			heap_mem[wa_h] <= wd_h;
		heap_rd_q <= heap_mem[ra_h];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q <= '0;
		end else if (cnt_clear) begin
			cnt_vld_q <= '0;
		end else if (cnt_we) begin
			cnt_vld_q[cnt_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			u_q     <= '0;
			fill_q  <= '0;
			next_q  <= '0;
			s_q     <= '0;
			mode_q  <= MD_HEAP;
			i_q     <= '0;
			hi_q    <= '0;
			rv_q    <= 1'b0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (build_start) begin
						s_q     <= '0;
						u_q     <= '0;
						fill_q  <= '0;
						state_q <= SC_RD;
					end
				end
				SC_RD: state_q <= SC_WR;
				SC_WR: begin
					if (we_w)
						u_q <= u_q + (NW+1)'(1);
					if (s_q == (SW+1)'(SYMBOLS - 1)) begin
						state_q <= SC_END;
					end else begin
						s_q     <= s_q + (SW+1)'(1);
						state_q <= SC_RD;
					end
				end
				SC_END: begin
					fill_q <= u_q;
					next_q <= u_q;
					mode_q <= MD_HEAP;
					hi_q   <= NW'((u_q - (NW+1)'(2)) >> 1);
					i_q    <= NW'((u_q - (NW+1)'(2)) >> 1);
					state_q <= (u_q >= (NW+1)'(2)) ? SD_START : B_DONE;
				end
				HP_NEXT: begin
					if (hi_q == '0) begin
						state_q <= M_TOP;
					end else begin
						hi_q    <= hi_q - NW'(1);
						i_q     <= hi_q - NW'(1);
						state_q <= SD_START;
					end
				end
				SD_START: state_q <= SD_LDN;
				SD_LDN: begin
					n_q     <= heap_rd_q;
					pw_q    <= w_rd_q;
					state_q <= SD_LDW;
				end
				SD_LDW: begin
					w_q     <= w_rd_q;
					state_q <= SD_L;
				end
				SD_L: begin
					rv_q    <= 1'b0;
					state_q <= (l_pos < (NW+2)'(fill_q)) ? SD_LN : SD_END;
				end
				SD_LN: begin
					ln_q    <= heap_rd_q;
					state_q <= SD_LW;
				end
				SD_LW: begin
					lw_q    <= w_rd_q;
					state_q <= (r_pos < (NW+2)'(fill_q)) ? SD_RN : SD_CMP;
				end
				SD_RN: begin
					rn_q    <= heap_rd_q;
					state_q <= SD_RW;
				end
				SD_RW: begin
					rw_q    <= w_rd_q;
					rv_q    <= 1'b1;
					state_q <= SD_CMP;
				end
				SD_CMP: begin
					if (sel_r) begin
						i_q     <= r_pos[NW-1:0];
						state_q <= SD_L;
					end else if (sel_l) begin
						i_q     <= l_pos[NW-1:0];
						state_q <= SD_L;
					end else begin
						state_q <= SD_END;
					end
				end
				SD_END: begin
					priority case (mode_q)
						MD_POPA: begin
							a_q     <= popped_q;
							wa_q    <= pw_q;
							mode_q  <= MD_POPB;
							state_q <= P0;
						end
						MD_POPB: state_q <= M_JOIN;
						default: state_q <= HP_NEXT;
					endcase
				end
				M_TOP: begin
					if (fill_q > (NW+1)'(1)) begin
						mode_q  <= MD_POPA;
						state_q <= P0;
					end else begin
						state_q <= B_DONE;
					end
				end
				P0: state_q <= P1;
				P1: begin
					popped_q <= heap_rd_q;
					fill_q   <= fill_q - (NW+1)'(1);
					i_q      <= '0;
					state_q  <= SD_LDN;
				end
				M_JOIN: begin
					w_q     <= sum_w;
					i_q     <= fill_q[NW-1:0];
					fill_q  <= fill_q + (NW+1)'(1);
					state_q <= PU_L;
				end
				PU_L: state_q <= (i_q == '0) ? PU_END : PU_PN;
				PU_PN: begin
					pn_q    <= heap_rd_q;
					state_q <= PU_PW;
				end
				PU_PW: begin
					if (w_q < w_rd_q) begin
						i_q     <= par_pos;
						state_q <= PU_L;
					end else begin
						state_q <= PU_END;
					end
				end
				PU_END: begin
					next_q  <= next_q + (NW+1)'(1);
					state_q <= M_TOP;
				end
				B_DONE: state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign build_done = state_q == B_DONE;
	assign leaf_total = u_q;
	assign tree_root  = (u_q >= (NW+1)'(2)) ? NW'((u_q << 1) - (NW+1)'(2)) : '0;

`ifndef SYNTHESIS
	a_done_fill: assert property (@(posedge clk) disable iff (!arst_n)
		build_done |-> fill_q <= (NW+1)'(1))
		else $error("tree build ended with more than one heap entry");
	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != B_IDLE |-> fill_q <= u_q)
		else $error("heap fill exceeds leaf count");
	a_next_cap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == M_JOIN |-> next_q < (NW+1)'(NODE_SLOTS))
		else $error("merged node beyond node memory");
`endif

endmodule

### rtl/huffman_stream_decoder.sv
// Top level: command intake, node memory, bit-serial tree walk and result registers.
//
//  channel | handshake            | words
//  in      | in_valid / in_ready  | cmd, symbol_index, symbol_count, stream_byte,
//          |                      | original_length, bit_total
//  out     | out_valid / out_ready| decoded_symbol, is_status, status_code,
//          |                      | decoded_total, last
//
// Start and count words are taken without leaving idle. No clearing pass after reset.
// The first stream or end word after loading builds the tree: a leaf scan over all
// symbols, then heapify, pops and pushes.
// A stream byte goes from acceptance to the next ready through a node fetch, eight bit
// steps with one node memory read each, an emit step per symbol found by the walk and
// a flush step that hands over the last result. An end word goes through a prep step
// and a status step. A full pending stage with a stalled output register holds the walk.
module huffman_stream_decoder
	import hsd_pkg::*;
#(
	parameter int SYMBOLS    = 256,
	parameter int NODE_SLOTS = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic [BYTE_W-1:0]  symbol_index,
	input  logic [WORD_W-1:0]  symbol_count,
	input  logic [BYTE_W-1:0]  stream_byte,
	input  logic [WORD_W-1:0]  original_length,
	input  logic [WORD_W-1:0]  bit_total,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [BYTE_W-1:0]  decoded_symbol,
	output logic               is_status,
	output logic [1:0]         status_code,
	output logic [WORD_W-1:0]  decoded_total,
	output logic               last
);

	localparam int SW = $clog2(SYMBOLS);
	localparam int NW = $clog2(NODE_SLOTS);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_BUILD = 3'd1;
	localparam logic [2:0] S_PREP  = 3'd2;
	localparam logic [2:0] S_BIT   = 3'd3;
	localparam logic [2:0] S_EMIT  = 3'd4;
	localparam logic [2:0] S_FLUSH = 3'd5;
	localparam logic [2:0] S_STAT  = 3'd6;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_LOAD = 2'd1;
	localparam logic [1:0] PH_DEC  = 2'd2;
	localparam logic [1:0] PH_DONE = 2'd3;

	logic [2*NW+BYTE_W-1:0] node_mem [NODE_SLOTS];
	logic [2*NW+BYTE_W-1:0] node_rd_q;

	logic [2:0]        state_q;
	logic [1:0]        phase_q;
	logic [WORD_W-1:0] tl_q, tb_q, em_q, bits_q;
	logic [NW-1:0]     cur_q;
	logic [2:0]        bitcnt_q;
	logic [BYTE_W-1:0] byte_q;
	logic              end_cmd_q, end_q;

	logic              pend_v_q;
	logic [BYTE_W-1:0] pend_sym_q;
	logic [WORD_W-1:0] pend_tot_q;

	logic              out_v_q, out_st_q, out_last_q;
	logic [BYTE_W-1:0] out_sym_q;
	logic [1:0]        out_code_q;
	logic [WORD_W-1:0] out_tot_q;

	logic              accept, cnt_clear, cnt_we, build_start, build_done;
	logic [NW:0]       leaf_total;
	logic [NW-1:0]     tree_root;
	logic              node_we;
	logic [NW-1:0]     node_addr, node_left, node_right, node_ra;
	logic [BYTE_W-1:0] node_sym;

	logic [NW-1:0]     q_left, q_right, nxt;
	logic [BYTE_W-1:0] q_sym;
	logic              bit_val, single, walk, is_leaf, out_free, emit_req, emit_ok;
	logic              out_load;
	logic [1:0]        code;

	assign accept      = in_valid && in_ready;
	assign in_ready    = state_q == S_IDLE;
	assign cnt_clear   = accept && cmd == CMD_START;
	assign cnt_we      = accept && cmd == CMD_COUNT && phase_q == PH_LOAD
	                     && {1'b0, symbol_index} < 9'(SYMBOLS);
	assign build_start = accept && (cmd == CMD_BYTE || cmd == CMD_END) && phase_q == PH_LOAD;

	hsd_tree_build #(
		.SYMBOLS    (SYMBOLS),
		.NODE_SLOTS (NODE_SLOTS)
	) u_build (
		.clk         (clk),
		.arst_n      (arst_n),
		.cnt_clear   (cnt_clear),
		.cnt_we      (cnt_we),
		.cnt_idx     (symbol_index[SW-1:0]),
		.cnt_data    (symbol_count),
		.build_start (build_start),
		.build_done  (build_done),
		.leaf_total  (leaf_total),
		.tree_root   (tree_root),
		.node_we     (node_we),
		.node_addr   (node_addr),
		.node_left   (node_left),
		.node_right  (node_right),
		.node_sym    (node_sym)
	);

	assign {q_left, q_right, q_sym} = node_rd_q;
	assign bit_val  = bits_q < tb_q && em_q < tl_q && leaf_total != '0;
	assign single   = leaf_total == (NW+1)'(1);
	assign walk     = state_q == S_BIT && bit_val && !single;
	assign nxt      = byte_q[bitcnt_q] ? q_right : q_left;
	assign is_leaf  = {1'b0, nxt} < leaf_total;
	assign out_free = !out_v_q || out_ready;
	assign emit_req = (state_q == S_BIT && bit_val && single) || state_q == S_EMIT;
	assign emit_ok  = !pend_v_q || out_free;
	assign out_load = (emit_req && emit_ok && pend_v_q)
	                  || (state_q == S_FLUSH && pend_v_q && out_free)
	                  || (state_q == S_STAT && out_free);

	always_comb begin
		priority if (bits_q < tb_q)
			code = ST_SHORT;
		else if (tl_q == '0)
			code = ST_OK;
		else if (leaf_total == '0)
			code = ST_NO_SYM;
		else if (em_q != tl_q)
			code = ST_MISMATCH;
		else
			code = ST_OK;
	end

	always_comb begin
		unique case (state_q)
			S_BIT:  node_ra = walk ? nxt : cur_q;
			S_EMIT: node_ra = emit_ok ? tree_root : cur_q;
			default: node_ra = cur_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (node_we)
			node_mem[node_addr] <= {node_left, node_right, node_sym};
		node_rd_q <= node_mem[node_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			phase_q   <= PH_IDLE;
			tl_q      <= '0;
			tb_q      <= '0;
			em_q      <= '0;
			bits_q    <= '0;
			cur_q     <= '0;
			bitcnt_q  <= '0;
			end_cmd_q <= 1'b0;
			end_q     <= 1'b0;
			pend_v_q  <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (out_load)
				out_v_q <= 1'b1;
			else if (out_ready)
				out_v_q <= 1'b0;

			if (emit_req && emit_ok) begin
				if (pend_v_q) begin
					out_sym_q  <= pend_sym_q;
					out_st_q   <= 1'b0;
					out_code_q <= ST_OK;
					out_tot_q  <= pend_tot_q;
					out_last_q <= 1'b0;
				end
				pend_v_q   <= 1'b1;
				pend_sym_q <= q_sym;
				pend_tot_q <= em_q + WORD_W'(1);
				em_q       <= em_q + WORD_W'(1);
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (cmd)
							CMD_START: begin
								tl_q    <= original_length;
								tb_q    <= bit_total;
								em_q    <= '0;
								bits_q  <= '0;
								cur_q   <= '0;
								phase_q <= PH_LOAD;
							end
							CMD_COUNT: begin
							end
							default: begin
								byte_q    <= stream_byte;
								end_cmd_q <= cmd == CMD_END;
								if (phase_q == PH_LOAD)
									state_q <= S_BUILD;
								else if (phase_q == PH_DEC)
									state_q <= S_PREP;
							end
						endcase
					end
				end
				S_BUILD: begin
					if (build_done) begin
						phase_q <= PH_DEC;
						cur_q   <= tree_root;
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					bitcnt_q <= 3'd7;
					state_q  <= end_cmd_q ? S_STAT : S_BIT;
				end
				S_BIT: begin
					if (!(emit_req && !emit_ok)) begin
						if (bits_q != '1)
							bits_q <= bits_q + WORD_W'(1);
						bitcnt_q <= bitcnt_q - 3'd1;
						end_q    <= bitcnt_q == 3'd0;
						if (walk)
							cur_q <= nxt;
						if (walk && is_leaf)
							state_q <= S_EMIT;
						else if (bitcnt_q == 3'd0)
							state_q <= S_FLUSH;
					end
				end
				S_EMIT: begin
					if (emit_ok) begin
						cur_q   <= tree_root;
						state_q <= end_q ? S_FLUSH : S_BIT;
					end
				end
				S_FLUSH: begin
					if (!pend_v_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						out_sym_q  <= pend_sym_q;
						out_st_q   <= 1'b0;
						out_code_q <= ST_OK;
						out_tot_q  <= pend_tot_q;
						out_last_q <= 1'b1;
						pend_v_q   <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				S_STAT: begin
					if (out_free) begin
						out_sym_q  <= '0;
						out_st_q   <= 1'b1;
						out_code_q <= code;
						out_tot_q  <= em_q;
						out_last_q <= 1'b1;
						phase_q    <= PH_DONE;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid      = out_v_q;
	assign decoded_symbol = out_sym_q;
	assign is_status      = out_st_q;
	assign status_code    = out_code_q;
	assign decoded_total  = out_tot_q;
	assign last           = out_last_q;

`ifndef SYNTHESIS
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_status |-> last)
		else $error("status word without last mark");
	a_em_bound: assert property (@(posedge clk) disable iff (!arst_n)
		em_q <= tl_q)
		else $error("decoded count passed the original length");
	a_idle_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !pend_v_q)
		else $error("pending symbol left behind at idle");
`endif

endmodule

### bench/tb.sv
// Self-checking bench for huffman_stream_decoder: queued jobs, tree predictor, random handshakes.
`timescale 1ns / 1ps

module tb;
	import hsd_pkg::*;

	localparam int NSYM  = 256;
	localparam int NNODE = 512;
	localparam int LIMIT = 400000;

	typedef enum logic [1:0] {JOB_IDLE, JOB_LOAD, JOB_DECODE, JOB_DONE} job_phase_t;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [BYTE_W-1:0] idx;
		logic [WORD_W-1:0] cnt;
		logic [BYTE_W-1:0] data;
		logic [WORD_W-1:0] len;
		logic [WORD_W-1:0] bits;
	} word_t;

	typedef struct packed {
		logic [BYTE_W-1:0] sym;
		logic              st;
		logic [1:0]        code;
		logic [WORD_W-1:0] total;
		logic              lst;
	} result_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [1:0] cmd = CMD_START;
	logic [BYTE_W-1:0] symbol_index = 0;
	logic [WORD_W-1:0] symbol_count = 0;
	logic [BYTE_W-1:0] stream_byte = 0;
	logic [WORD_W-1:0] original_length = 0;
	logic [WORD_W-1:0] bit_total = 0;
	logic out_valid;
	logic out_ready = 0;
	logic [BYTE_W-1:0] decoded_symbol;
	logic is_status;
	logic [1:0] status_code;
	logic [WORD_W-1:0] decoded_total;
	logic last;

	huffman_stream_decoder dut (.*);

	always #6 clk = ~clk;

	word_t   pending_words[$];
	result_t expected_results[$];
	int      mismatches = 0;
	int      results_seen = 0;
	int      cycles = 0;

	// decoder shadow state
	logic [WORD_W-1:0] counts[NSYM];
	logic [WORD_W-1:0] weight[NNODE];
	logic [BYTE_W-1:0] leaf_sym[NNODE];
	int                kid_l[NNODE];
	int                kid_r[NNODE];
	int                heap[NNODE];
	int                heap_n, root, walk, leaves;
	logic [WORD_W-1:0] emitted, consumed, want_len, want_bits;
	job_phase_t        phase = JOB_IDLE;

	initial begin
		foreach (counts[i]) counts[i] = 0;
		heap_n = 0; root = 0; walk = 0; leaves = 0;
		emitted = 0; consumed = 0; want_len = 0; want_bits = 0;
	end

	function automatic void sift(int i);
		int s, l, r, t;
		forever begin
			s = i; l = 2 * i + 1; r = 2 * i + 2;
			if (l < heap_n && weight[heap[l]] < weight[heap[s]]) s = l;
			if (r < heap_n && weight[heap[r]] < weight[heap[s]]) s = r;
			if (s == i) return;
			t = heap[s]; heap[s] = heap[i]; heap[i] = t;
			i = s;
		end
	endfunction

	function automatic int heap_take();
		int n;
		n = heap[0];
		heap_n--;
		heap[0] = heap[heap_n];
		sift(0);
		return n;
	endfunction

	function automatic void heap_add(int n);
		int i;
		if (heap_n >= NNODE) return;
		i = heap_n++;
		while (i > 0 && weight[n] < weight[heap[(i - 1) / 2]]) begin
			heap[i] = heap[(i - 1) / 2];
			i = (i - 1) / 2;
		end
		heap[i] = n;
	endfunction

	function automatic void grow_tree();
		int u, nxt, a, b;
		u = 0;
		for (int s = 0; s < NSYM; s++) begin
			if (counts[s] != 0 && u < (NNODE + 1) / 2) begin
				weight[u] = counts[s];
				leaf_sym[u] = 8'(s);
				kid_l[u] = 0; kid_r[u] = 0;
				heap[u] = u;
				u++;
			end
		end
		leaves = u;
		heap_n = u;
		if (u >= 2)
			for (int i = (u - 2) / 2; i >= 0; i--) sift(i);
		nxt = u;
		while (heap_n > 1 && nxt < NNODE) begin
			a = heap_take();
			b = heap_take();
			weight[nxt] = weight[a] + weight[b];
			leaf_sym[nxt] = '0;
			kid_l[nxt] = a;
			kid_r[nxt] = b;
			heap_add(nxt);
			nxt++;
		end
		root = (u != 0) ? heap_take() : 0;
		walk = root;
		phase = JOB_DECODE;
	endfunction

	function automatic void emit(logic [BYTE_W-1:0] s, logic st, logic [1:0] code);
		result_t r;
		r.sym = s; r.st = st; r.code = code; r.total = emitted; r.lst = 0;
		expected_results.push_back(r);
	endfunction

	function automatic void decode_word(word_t w);
		int n_prior;
		logic [1:0] code;
		n_prior = expected_results.size();
		case (w.cmd)
			CMD_START: begin
				foreach (counts[i]) counts[i] = 0;
				want_len = w.len; want_bits = w.bits;
				emitted = 0; consumed = 0;
				heap_n = 0; leaves = 0; root = 0; walk = 0;
				phase = JOB_LOAD;
				return;
			end
			CMD_COUNT: begin
				if (phase == JOB_LOAD) counts[w.idx] = w.cnt;
				return;
			end
			default: ;
		endcase
		if (phase == JOB_LOAD) grow_tree();
		if (phase != JOB_DECODE) return;
		if (w.cmd == CMD_BYTE) begin
			for (int b = 7; b >= 0; b--) begin
				if (consumed < want_bits && emitted < want_len && leaves > 0) begin
					if (leaves == 1) begin
						emitted++;
						emit(leaf_sym[root % NNODE], 1'b0, ST_OK);
					end else begin
						walk = w.data[b] ? kid_r[walk % NNODE] : kid_l[walk % NNODE];
						if (walk >= NNODE) walk = root;
						if (walk < leaves) begin
							emitted++;
							emit(leaf_sym[walk], 1'b0, ST_OK);
							walk = root;
						end
					end
				end
				if (consumed != '1) consumed++;
			end
		end else begin
			if (consumed < want_bits) code = ST_SHORT;
			else if (want_len == 0) code = ST_OK;
			else if (leaves == 0) code = ST_NO_SYM;
			else if (emitted != want_len) code = ST_MISMATCH;
			else code = ST_OK;
			emit('0, 1'b1, code);
			phase = JOB_DONE;
		end
		if (expected_results.size() > n_prior)
			expected_results[$].lst = 1;
	endfunction

	function automatic void queue_word(logic [1:0] c, logic [7:0] i, logic [31:0] n,
			logic [7:0] d, logic [31:0] len, logic [31:0] bits);
		word_t w;
		w.cmd = c; w.idx = i; w.cnt = n; w.data = d; w.len = len; w.bits = bits;
		pending_words.push_back(w);
	endfunction

	function automatic logic [31:0] rnd32();
		return $urandom;
	endfunction

	// one job with random content and an optional end word
	function automatic void queue_job(int nsym, int nbytes, logic [31:0] len,
			logic [31:0] bits, bit with_end);
		logic [31:0] c;
		queue_word(CMD_START, 8'($urandom), rnd32(), 8'($urandom), len, bits);
		for (int k = 0; k < nsym; k++) begin
			c = ($urandom_range(0, 9) == 0) ? rnd32() : $urandom_range(1, 40);
			queue_word(CMD_COUNT, 8'($urandom), c, 8'($urandom), rnd32(), rnd32());
		end
		for (int k = 0; k < nbytes; k++)
			queue_word(CMD_BYTE, 8'($urandom), rnd32(), 8'($urandom), rnd32(), rnd32());
		if (with_end)
			queue_word(CMD_END, 8'($urandom), rnd32(), 8'($urandom), rnd32(), rnd32());
	endfunction

	// sender
	logic in_taken = 0;
	int   send_gap = 0;
	bit   send_calm = 0;
	always @(posedge clk) begin
		in_taken <= in_valid && in_ready;
		if (in_valid && in_ready)
			decode_word({cmd, symbol_index, symbol_count, stream_byte, original_length,
				bit_total});
	end

	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 0;
			end else if (pending_words.size() != 0) begin
				word_t w;
				w = pending_words.pop_front();
				cmd <= w.cmd; symbol_index <= w.idx; symbol_count <= w.cnt;
				stream_byte <= w.data; original_length <= w.len; bit_total <= w.bits;
				in_valid <= 1;
				if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
				send_gap <= send_calm ? 0 : $urandom_range(0, 9);
			end else begin
				in_valid <= 0;
			end
		end
	end

	// receiver
	logic out_taken = 0;
	int   recv_gap = 0;
	int   hold = 0;
	bit   held = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (!held && results_seen >= 30) begin
				held <= 1;
				hold <= 600;
				out_ready <= 0;
			end else if (hold != 0) begin
				hold <= hold - 1;
				out_ready <= 0;
			end else if (!out_ready || out_taken) begin
				if (recv_gap != 0) begin
					recv_gap <= recv_gap - 1;
					out_ready <= 0;
				end else begin
					out_ready <= 1;
					recv_gap <= send_calm ? 0 : $urandom_range(0, 9);
				end
			end
		end
	end

	always @(posedge clk) begin
		out_taken <= out_valid && out_ready;
		if (out_valid && out_ready) begin
			results_seen <= results_seen + 1;
			if (expected_results.size() == 0) begin
				$error("unexpected result: symbol %0d status %0b", decoded_symbol, is_status);
				mismatches++;
			end else begin
				result_t e;
				e = expected_results.pop_front();
				if (decoded_symbol !== e.sym) begin
					$error("decoded_symbol: expected %0d, got %0d", e.sym, decoded_symbol);
					mismatches++;
				end
				if (is_status !== e.st) begin
					$error("is_status: expected %0d, got %0d", e.st, is_status);
					mismatches++;
				end
				if (status_code !== e.code) begin
					$error("status_code: expected %0d, got %0d", e.code, status_code);
					mismatches++;
				end
				if (decoded_total !== e.total) begin
					$error("decoded_total: expected %0d, got %0d", e.total, decoded_total);
					mismatches++;
				end
				if (last !== e.lst) begin
					$error("last: expected %0d, got %0d", e.lst, last);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("[huffman_stream_decoder] ERROR");
			$finish;
		end
	end

	initial begin
		int nb, ns;
		logic [31:0] len, bits;
		// stray words before any job
		queue_word(CMD_BYTE, 8'h00, 0, 8'hFF, 0, 0);
		queue_word(CMD_COUNT, 8'hFF, '1, 8'h00, '1, '1);
		queue_word(CMD_END, 0, 0, 0, 0, 0);
		// extremes of index and count, wrapping weights
		queue_word(CMD_START, 0, 0, 0, 32'd12, 32'd16);
		queue_word(CMD_COUNT, 8'h00, 32'hFFFF_FFFF, 0, 0, 0);
		queue_word(CMD_COUNT, 8'hFF, 32'd1, 0, 0, 0);
		queue_word(CMD_COUNT, 8'h80, 32'd1, 0, 0, 0);
		queue_word(CMD_BYTE, 0, 0, 8'h00, 0, 0);
		queue_word(CMD_BYTE, 0, 0, 8'hFF, 0, 0);
		queue_word(CMD_END, 0, 0, 0, 0, 0);
		queue_word(CMD_BYTE, 0, 0, 8'hA5, 0, 0);
		queue_word(CMD_COUNT, 8'h01, 32'd3, 0, 0, 0);
		// single symbol, trailing bits past the length
		queue_word(CMD_START, 0, 0, 0, 32'd5, 32'd8);
		queue_word(CMD_COUNT, 8'h41, 32'd7, 0, 0, 0);
		queue_word(CMD_BYTE, 0, 0, 8'h5A, 0, 0);
		queue_word(CMD_END, 0, 0, 0, 0, 0);
		// no symbols, stream too short
		queue_word(CMD_START, 0, 0, 0, 32'd3, 32'd8);
		queue_word(CMD_END, 0, 0, 0, 0, 0);
		queue_word(CMD_START, 0, 0, 0, 32'd3, 32'hFFFF_FFFF);
		queue_word(CMD_COUNT, 8'h10, 32'd2, 0, 0, 0);
		queue_word(CMD_COUNT, 8'h20, 32'd2, 0, 0, 0);
		queue_word(CMD_BYTE, 0, 0, 8'h6C, 0, 0);
		queue_word(CMD_END, 0, 0, 0, 0, 0);
		// zero length
		queue_word(CMD_START, 0, 0, 0, 32'd0, 32'd0);
		queue_word(CMD_END, 0, 0, 0, 0, 0);
		while (pending_words.size() < 120) begin
			ns = ($urandom_range(0, 12) == 0) ? 0 : $urandom_range(1, 7);
			nb = $urandom_range(1, 6);
			bits = 8 * nb - (($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : 0);
			if ($urandom_range(0, 7) == 0) bits = 8 * nb + $urandom_range(1, 8);
			len = $urandom_range(0, 3) == 0 ? rnd32() % 40 : $urandom_range(1, 3 * nb);
			queue_job(ns, nb, len, bits, $urandom_range(0, 9) != 0);
			if ($urandom_range(0, 5) == 0)
				queue_word(2'($urandom_range(1, 3)), 8'($urandom), rnd32(), 8'($urandom),
					rnd32(), rnd32());
		end
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1;
		wait (pending_words.size() == 0 && !in_valid);
		wait (expected_results.size() == 0);
		repeat (1200) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("[huffman_stream_decoder] OK");
		else
			$display("[huffman_stream_decoder] ERROR");
		$finish;
	end

endmodule
